FILE: rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expands to one labeled concurrent assertion
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication check failed");

// next-cycle implication, disabled while reset is low
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

FILE: rtl/msdch_pkg.sv
// shared types and constants for the switch debouncer with bank-hold gesture
// no dependencies; used by every rtl module
package msdch_pkg;

  localparam int NUM_SW        = 6;
  localparam int TIME_BITS     = 32;
  localparam int DEB_BITS      = 8;
  localparam int LONG_BITS     = 16;
  localparam int CFG_IDX_BITS  = 8;
  localparam int CFG_DATA_BITS = 32;

  localparam int BANK_A = NUM_SW - 2;
  localparam int BANK_B = NUM_SW - 1;

  localparam logic [DEB_BITS-1:0]  DEB_RESET  = DEB_BITS'(20);
  localparam logic [LONG_BITS-1:0] LONG_RESET = LONG_BITS'(1000);

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_DEBOUNCE   = CFG_IDX_BITS'(0),
    REG_LONG_PRESS = CFG_IDX_BITS'(1)
  } reg_idx_t;

  typedef struct packed {
    logic [TIME_BITS-1:0] now_ms;
    logic [NUM_SW-1:0]    raw_levels;
  } in_t;

  typedef struct packed {
    logic [NUM_SW-1:0] press_edges;
    logic [NUM_SW-1:0] held_now;
    logic              gesture_fired;
  } out_t;

  // what one lane reports for the current beat
  typedef struct packed {
    logic stable;
    logic press;
  } lane_res_t;

endpackage

FILE: rtl/msdch_lane.sv
// one switch debounce lane: last raw level, change time and stable level
// depends on msdch_pkg
module msdch_lane (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 accept,
  input  logic [msdch_pkg::TIME_BITS-1:0]      now_ms,
  input  logic                                 raw,
  input  logic [msdch_pkg::DEB_BITS-1:0]       deb_limit,
  output msdch_pkg::lane_res_t                 res
);

  localparam int TB = msdch_pkg::TIME_BITS;
  localparam int DB = msdch_pkg::DEB_BITS;

  logic          last_raw_r, last_raw_nxt;
  logic [TB-1:0] change_time_r, change_time_nxt;
  logic          stable_r, stable_nxt;
  logic [TB-1:0] elapsed;
  logic          settled;
  logic          upd;

  always_comb begin
    last_raw_nxt    = raw;
    change_time_nxt = (raw != last_raw_r) ? now_ms : change_time_r;
    elapsed         = now_ms - change_time_nxt;
    settled         = elapsed >= {{(TB-DB){1'b0}}, deb_limit};
    upd             = settled && (raw != stable_r);
    stable_nxt      = upd ? raw : stable_r;
    res.stable      = stable_nxt;
    res.press       = upd && !raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r    <= 1'b1;
      change_time_r <= '0;
      stable_r      <= 1'b1;
    end else if (accept) begin
      last_raw_r    <= last_raw_nxt;
      change_time_r <= change_time_nxt;
      stable_r      <= stable_nxt;
    end
  end

endmodule

FILE: rtl/msdch_merge.sv
// merge stage: gathers lane results, runs the bank-hold gesture, output register
// depends on msdch_pkg
module msdch_merge (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  logic                                     accept,
  input  logic [msdch_pkg::TIME_BITS-1:0]          now_ms,
  input  msdch_pkg::lane_res_t [msdch_pkg::NUM_SW-1:0] lanes,
  input  logic [msdch_pkg::LONG_BITS-1:0]          hold_limit,
  input  logic                                     out_stall,
  output logic                                     out_valid,
  output msdch_pkg::out_t                          out_data
);

  localparam int TB = msdch_pkg::TIME_BITS;
  localparam int LB = msdch_pkg::LONG_BITS;
  localparam int NS = msdch_pkg::NUM_SW;

  logic          hold_active_r, hold_active_nxt;
  logic          latched_r, latched_nxt;
  logic [TB-1:0] hold_start_r, hold_start_nxt;
  logic          out_valid_r, out_valid_nxt;
  msdch_pkg::out_t out_data_r, out_data_nxt;
  logic [NS-1:0] held;
  logic [NS-1:0] edges;
  logic [TB-1:0] hold_elapsed;
  logic          fired;

  always_comb begin
    for (int i = 0; i < NS; i++) begin
      held[i]  = !lanes[i].stable;
      edges[i] = lanes[i].press;
    end
    hold_active_nxt = hold_active_r;
    latched_nxt     = latched_r;
    hold_start_nxt  = hold_start_r;
    fired           = 1'b0;
    hold_elapsed    = now_ms - hold_start_r;
    if (held[msdch_pkg::BANK_A] && held[msdch_pkg::BANK_B]) begin
      if (!hold_active_r) begin
        // first tick of the hold only arms the timer
        hold_active_nxt = 1'b1;
        hold_start_nxt  = now_ms;
        latched_nxt     = 1'b0;
      end else if (!latched_r && (hold_elapsed >= {{(TB-LB){1'b0}}, hold_limit})) begin
        latched_nxt = 1'b1;
        fired       = 1'b1;
      end
    end else begin
      hold_active_nxt = 1'b0;
      latched_nxt     = 1'b0;
    end
    out_data_nxt.press_edges   = edges;
    out_data_nxt.held_now      = held;
    out_data_nxt.gesture_fired = fired;
    // output register refills on accept, drains when the sink takes the beat
    if (accept) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_active_r <= 1'b0;
      latched_r     <= 1'b0;
      hold_start_r  <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        hold_active_r <= hold_active_nxt;
        latched_r     <= latched_nxt;
        hold_start_r  <= hold_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data_r <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/multi_switch_debounce_combo_hold.sv
// Six-switch debouncer with a long-press gesture on the two bank switches
// (switches 4 and 5). One sample beat is taken every clock cycle while not
// stalled; its result appears from the output register on the next cycle, and
// throughput is one beat per cycle. All switch lanes update in parallel in the
// accepting cycle (one 32-bit subtract and compare per lane), and the merge
// stage runs the gesture timer in the same cycle. in_stall rises only while a
// result sits in the output register and the sink stalls. Configuration
// writes are always ready and take effect on the next accepted beat.
// depends on msdch_pkg, msdch_lane, msdch_merge
module multi_switch_debounce_combo_hold (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  msdch_pkg::in_t                         in_data,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output msdch_pkg::out_t                        out_data,
  input  logic                                   cfg_valid,
  output logic                                   cfg_ready,
  input  logic [msdch_pkg::CFG_IDX_BITS-1:0]     cfg_index,
  input  logic [msdch_pkg::CFG_DATA_BITS-1:0]    cfg_data
);

  localparam int NS = msdch_pkg::NUM_SW;
  localparam int DB = msdch_pkg::DEB_BITS;
  localparam int LB = msdch_pkg::LONG_BITS;

  logic          accept;
  logic [DB-1:0] debounce_r, debounce_nxt;
  logic [LB-1:0] long_press_r, long_press_nxt;
  msdch_pkg::lane_res_t [NS-1:0] lanes;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid && out_stall;
  assign accept    = in_valid && !in_stall;

  always_comb begin
    debounce_nxt   = debounce_r;
    long_press_nxt = long_press_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        msdch_pkg::REG_DEBOUNCE:   debounce_nxt   = cfg_data[DB-1:0];
        msdch_pkg::REG_LONG_PRESS: long_press_nxt = cfg_data[LB-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r   <= msdch_pkg::DEB_RESET;
      long_press_r <= msdch_pkg::LONG_RESET;
    end else begin
      debounce_r   <= debounce_nxt;
      long_press_r <= long_press_nxt;
    end
  end

  for (genvar g = 0; g < NS; g++) begin : g_lane
    msdch_lane u_lane (
      .clk       (clk),
      .rst_n     (rst_n),
      .accept    (accept),
      .now_ms    (in_data.now_ms),
      .raw       (in_data.raw_levels[g]),
      .deb_limit (debounce_r),
      .res       (lanes[g])
    );
  end

  msdch_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .now_ms     (in_data.now_ms),
    .lanes      (lanes),
    .hold_limit (long_press_r),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .out_data   (out_data)
  );

endmodule

FILE: rtl/msdch_checker.sv
// port-level checks for the debouncer, attached to the top level by bind
// depends on msdch_pkg and assert_macros.svh
`include "assert_macros.svh"

module msdch_checker (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_stall,
  input logic            out_valid,
  input logic            out_stall,
  input msdch_pkg::out_t out_data
);

  // a stalled result beat is still there next cycle
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  // an accepted sample beat always has its result up on the next cycle
  `ASSERT_NEXT(a_accept_fills, clk, rst_n, in_valid && !in_stall, out_valid)
  // input backs up only behind a full, stalled output register
  `ASSERT_IMPL(a_stall_cause, clk, rst_n, in_stall, out_valid && out_stall)
  // a press edge always shows as held on the same beat
  `ASSERT_IMPL(a_edge_held, clk, rst_n, out_valid,
               (out_data.press_edges & ~out_data.held_now) == '0)
  // gesture only fires with both bank switches held
  `ASSERT_IMPL(a_gesture_bank, clk, rst_n, out_valid && out_data.gesture_fired,
               out_data.held_now[msdch_pkg::BANK_A] && out_data.held_now[msdch_pkg::BANK_B])

endmodule

bind multi_switch_debounce_combo_hold msdch_checker u_msdch_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
